@@ sv/wsu_pkg.sv @@
// Shared types and constants for the WebSocket text frame unmasker.
`timescale 1ns / 1ps

package wsu_pkg;

   typedef enum logic [2:0] {
      PH_FIRST = 3'd0,
      PH_LEN   = 3'd1,
      PH_EXT   = 3'd2,
      PH_KEY   = 3'd3,
      PH_DATA  = 3'd4,
      PH_DROP  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      KIND_TEXT  = 3'd0,
      KIND_EMPTY = 3'd1,
      KIND_CLOSE = 3'd2,
      KIND_OTHER = 3'd3,
      KIND_TRUNC = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   frame_kind;
      logic [3:0] opcode;
      logic       out_last;
   } result_type;

   localparam logic [7:0] TEXT_FIN_BYTE  = 8'h81;
   localparam logic [7:0] CLOSE_FIN_BYTE = 8'h88;
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] EXT64_BYTES    = 4'd8;
   localparam logic [3:0] KEY_BYTES      = 4'd4;
   localparam logic [3:0] OPCODE_TEXT    = 4'h1;
   localparam logic [3:0] OPCODE_CLOSE   = 4'h8;

endpackage

@@ sv/websocket_text_frame_unmasker_top.sv @@
// Top level of the WebSocket text frame unmasker: header parse, unmask, output stage.
`timescale 1ns / 1ps

// Takes a received WebSocket frame one item (byte) per cycle while req_stall is low,
// req_in_last on the frame's last byte, and returns at most one result item per input
// item. A first byte of 0x81 starts a text frame: the length code and any extended
// length bytes are skipped, four mask key bytes are captured, and each payload byte
// comes out XORed with the key byte at (payload index mod 4). A text frame that ends
// inside its header gives one truncated item; one that ends on the last key byte
// gives one empty-text item. A close (0x88) or any other first byte gives one item on
// that byte and the rest of the frame is dropped silently. Rate: one input item per
// cycle while req_stall is low; a result reaches rsp_valid from the result register.
// The header phase machine and the XOR are combinational between the input and the
// result register; a two-entry output stage (result register plus skid register)
// keeps the input open while one result waits under rsp_stall, and req_stall is
// simply "skid register full". No clearing pass after reset.
module websocket_text_frame_unmasker_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_frame_kind,
   output logic [3:0] rsp_opcode,
   output logic       rsp_out_last
);

   // parse state
   wsu_pkg::phase_type phase_ff, phase_in;
   logic [3:0]         phase_count_ff, phase_count_in;
   logic [1:0]         key_index_ff, key_index_in;
   logic [7:0]         mask_key_ff [4];
   logic               key_we;
   logic [3:0]         count_inc;
   logic [3:0]         count_dec;

   // new result from the current item
   wsu_pkg::result_type res;
   logic                res_valid;

   // output stage: result register and skid register
   wsu_pkg::result_type rsp_ff, rsp_in, skid_ff, skid_in;
   logic                rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;

   logic req_accept;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;

   assign count_inc = phase_count_ff + 4'd1;
   assign count_dec = phase_count_ff - 4'd1;

   // Phase machine and result selection for one byte.
   always_comb begin
      phase_in       = phase_ff;
      phase_count_in = phase_count_ff;
      key_index_in   = key_index_ff;
      key_we         = 1'b0;
      res            = '{out_byte: 8'd0, frame_kind: wsu_pkg::KIND_TEXT,
                         opcode: wsu_pkg::OPCODE_TEXT, out_last: 1'b1};
      res_valid      = 1'b0;
      case (phase_ff)
         wsu_pkg::PH_LEN: begin
            if (req_in_last) begin
               phase_in       = wsu_pkg::PH_FIRST;
               res.frame_kind = wsu_pkg::KIND_TRUNC;
               res_valid      = 1'b1;
            end else if (req_in_byte[6:0] == wsu_pkg::LEN_CODE_EXT16) begin
               phase_in       = wsu_pkg::PH_EXT;
               phase_count_in = wsu_pkg::EXT16_BYTES;
            end else if (req_in_byte[6:0] == wsu_pkg::LEN_CODE_EXT64) begin
               phase_in       = wsu_pkg::PH_EXT;
               phase_count_in = wsu_pkg::EXT64_BYTES;
            end else begin
               phase_in       = wsu_pkg::PH_KEY;
               phase_count_in = 4'd0;
            end
         end
         wsu_pkg::PH_EXT: begin
            if (req_in_last) begin
               phase_in       = wsu_pkg::PH_FIRST;
               res.frame_kind = wsu_pkg::KIND_TRUNC;
               res_valid      = 1'b1;
            end else begin
               phase_count_in = count_dec;
               if (count_dec == 4'd0) begin
                  phase_in = wsu_pkg::PH_KEY;
               end
            end
         end
         wsu_pkg::PH_KEY: begin
            key_we = 1'b1;
            if (count_inc >= wsu_pkg::KEY_BYTES) begin
               phase_count_in = 4'd0;
               key_index_in   = 2'd0;
               if (req_in_last) begin
                  phase_in       = wsu_pkg::PH_FIRST;
                  res.frame_kind = wsu_pkg::KIND_EMPTY;
                  res_valid      = 1'b1;
               end else begin
                  phase_in = wsu_pkg::PH_DATA;
               end
            end else begin
               phase_count_in = count_inc;
               if (req_in_last) begin
                  phase_in       = wsu_pkg::PH_FIRST;
                  phase_count_in = 4'd0;
                  res.frame_kind = wsu_pkg::KIND_TRUNC;
                  res_valid      = 1'b1;
               end
            end
         end
         wsu_pkg::PH_DATA: begin
            key_index_in   = key_index_ff + 2'd1;
            res.out_byte   = req_in_byte ^ mask_key_ff[key_index_ff];
            res.frame_kind = wsu_pkg::KIND_TEXT;
            res.out_last   = req_in_last;
            res_valid      = 1'b1;
            if (req_in_last) begin
               phase_in = wsu_pkg::PH_FIRST;
            end
         end
         wsu_pkg::PH_DROP: begin
            if (req_in_last) begin
               phase_in = wsu_pkg::PH_FIRST;
            end
         end
         default: begin
            // first byte of a frame; unused phase codes land here too
            phase_count_in = 4'd0;
            key_index_in   = 2'd0;
            if (req_in_byte == wsu_pkg::TEXT_FIN_BYTE) begin
               if (req_in_last) begin
                  phase_in       = wsu_pkg::PH_FIRST;
                  res.frame_kind = wsu_pkg::KIND_TRUNC;
                  res_valid      = 1'b1;
               end else begin
                  phase_in = wsu_pkg::PH_LEN;
               end
            end else begin
               phase_in  = req_in_last ? wsu_pkg::PH_FIRST : wsu_pkg::PH_DROP;
               res_valid = 1'b1;
               if (req_in_byte == wsu_pkg::CLOSE_FIN_BYTE) begin
                  res.frame_kind = wsu_pkg::KIND_CLOSE;
                  res.opcode     = wsu_pkg::OPCODE_CLOSE;
               end else begin
                  res.frame_kind = wsu_pkg::KIND_OTHER;
                  res.opcode     = req_in_byte[3:0];
               end
            end
         end
      endcase
   end

   // Output stage: skid drains first; a stalled result register pushes new results
   // into the skid register (empty whenever an item is accepted).
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_valid_ff && rsp_stall) begin
         if (req_accept && res_valid) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_in        = skid_ff;
         rsp_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end else begin
         rsp_in       = res;
         rsp_valid_in = req_accept && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= wsu_pkg::PH_FIRST;
         phase_count_ff <= 4'd0;
         key_index_ff   <= 2'd0;
         mask_key_ff    <= '{default: 8'd0};
         rsp_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff       <= phase_in;
            phase_count_ff <= phase_count_in;
            key_index_ff   <= key_index_in;
            if (key_we) begin
               mask_key_ff[phase_count_ff[1:0]] <= req_in_byte;
            end
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_frame_kind = rsp_ff.frame_kind;
   assign rsp_opcode     = rsp_ff.opcode;
   assign rsp_out_last   = rsp_ff.out_last;

endmodule

@@ sv/wsu_checker.sv @@
// Port-level assertions for the unmasker top level, with bind.
`timescale 1ns / 1ps

module wsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_frame_kind,
   input logic [3:0] rsp_opcode,
   input logic       rsp_out_last
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_frame_kind) && $stable(rsp_opcode) && $stable(rsp_out_last))
      else $error("stalled result item changed");

   // input stalls only while a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending result");

   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_kind != wsu_pkg::KIND_TEXT) |-> rsp_out_byte == 8'd0)
      else $error("nonzero byte on non-text result");

   a_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_kind == wsu_pkg::KIND_CLOSE)
         |-> (rsp_opcode == wsu_pkg::OPCODE_CLOSE) && rsp_out_last)
      else $error("bad close result");

   a_header_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_frame_kind == wsu_pkg::KIND_EMPTY)
         || (rsp_frame_kind == wsu_pkg::KIND_TRUNC) || (rsp_frame_kind == wsu_pkg::KIND_TEXT))
         |-> rsp_opcode == wsu_pkg::OPCODE_TEXT)
      else $error("text-family result with wrong opcode");

endmodule

bind websocket_text_frame_unmasker_top wsu_checker u_wsu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_frame_kind (rsp_frame_kind),
   .rsp_opcode     (rsp_opcode),
   .rsp_out_last   (rsp_out_last)
);

@@ tb/wsu_unmask_checker.sv @@
// Checker for the frame unmasker: tracks the frame parse, predicts each result and compares it.
`timescale 1ns / 1ps

module wsu_unmask_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic [2:0] rsp_frame_kind,
   input  logic [3:0] rsp_opcode,
   input  logic       rsp_out_last,
   output int         mismatch_count,
   output int         pending_results
);

   wsu_pkg::phase_type  parse_phase;
   logic [3:0]          parse_count;
   logic [7:0]          mask_bytes [0:3];
   logic [1:0]          payload_index;
   wsu_pkg::result_type expected_results [$];

   task automatic push_result(input logic [7:0] b, input wsu_pkg::kind_type kind,
                              input logic [3:0] op, input logic last);
      wsu_pkg::result_type r;
      r.out_byte   = b;
      r.frame_kind = kind;
      r.opcode     = op;
      r.out_last   = last;
      expected_results.push_back(r);
   endtask

   task automatic parse_frame_byte(input logic [7:0] b, input logic last);
      case (parse_phase)
         wsu_pkg::PH_LEN: begin
            if (last) begin
               parse_phase = wsu_pkg::PH_FIRST;
               push_result(8'h00, wsu_pkg::KIND_TRUNC, wsu_pkg::OPCODE_TEXT, 1'b1);
            end else if (b[6:0] == wsu_pkg::LEN_CODE_EXT16) begin
               parse_phase = wsu_pkg::PH_EXT;
               parse_count = wsu_pkg::EXT16_BYTES;
            end else if (b[6:0] == wsu_pkg::LEN_CODE_EXT64) begin
               parse_phase = wsu_pkg::PH_EXT;
               parse_count = wsu_pkg::EXT64_BYTES;
            end else begin
               parse_phase = wsu_pkg::PH_KEY;
               parse_count = 4'd0;
            end
         end
         wsu_pkg::PH_EXT: begin
            if (last) begin
               parse_phase = wsu_pkg::PH_FIRST;
               push_result(8'h00, wsu_pkg::KIND_TRUNC, wsu_pkg::OPCODE_TEXT, 1'b1);
            end else begin
               parse_count = parse_count - 4'd1;
               if (parse_count == 4'd0) parse_phase = wsu_pkg::PH_KEY;
            end
         end
         wsu_pkg::PH_KEY: begin
            mask_bytes[parse_count[1:0]] = b;
            parse_count = parse_count + 4'd1;
            if (parse_count >= wsu_pkg::KEY_BYTES) begin
               parse_count   = 4'd0;
               payload_index = 2'd0;
               if (last) begin
                  parse_phase = wsu_pkg::PH_FIRST;
                  push_result(8'h00, wsu_pkg::KIND_EMPTY, wsu_pkg::OPCODE_TEXT, 1'b1);
               end else begin
                  parse_phase = wsu_pkg::PH_DATA;
               end
            end else if (last) begin
               parse_phase = wsu_pkg::PH_FIRST;
               parse_count = 4'd0;
               push_result(8'h00, wsu_pkg::KIND_TRUNC, wsu_pkg::OPCODE_TEXT, 1'b1);
            end
         end
         wsu_pkg::PH_DATA: begin
            push_result(b ^ mask_bytes[payload_index], wsu_pkg::KIND_TEXT,
                        wsu_pkg::OPCODE_TEXT, last);
            payload_index = payload_index + 2'd1;
            if (last) parse_phase = wsu_pkg::PH_FIRST;
         end
         wsu_pkg::PH_DROP: begin
            if (last) parse_phase = wsu_pkg::PH_FIRST;
         end
         default: begin
            parse_count   = 4'd0;
            payload_index = 2'd0;
            if (b == wsu_pkg::TEXT_FIN_BYTE) begin
               if (last) begin
                  parse_phase = wsu_pkg::PH_FIRST;
                  push_result(8'h00, wsu_pkg::KIND_TRUNC, wsu_pkg::OPCODE_TEXT, 1'b1);
               end else begin
                  parse_phase = wsu_pkg::PH_LEN;
               end
            end else begin
               parse_phase = last ? wsu_pkg::PH_FIRST : wsu_pkg::PH_DROP;
               if (b == wsu_pkg::CLOSE_FIN_BYTE)
                  push_result(8'h00, wsu_pkg::KIND_CLOSE, wsu_pkg::OPCODE_CLOSE, 1'b1);
               else push_result(8'h00, wsu_pkg::KIND_OTHER, b[3:0], 1'b1);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      wsu_pkg::result_type want;
      if (reset) begin
         parse_phase   = wsu_pkg::PH_FIRST;
         parse_count   = 4'd0;
         payload_index = 2'd0;
         for (int i = 0; i < 4; i++) mask_bytes[i] = 8'h00;
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         // results first: one accepted now cannot stem from an item accepted now
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result byte %02h kind %0d opcode %0d last %0d",
                        $time, rsp_out_byte, rsp_frame_kind, rsp_opcode, rsp_out_last);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, want.out_byte, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_frame_kind !== want.frame_kind) begin
                  $display("%0t: frame_kind expected %0d actual %0d",
                           $time, want.frame_kind, rsp_frame_kind);
                  mismatch_count++;
               end
               if (rsp_opcode !== want.opcode) begin
                  $display("%0t: opcode expected %0d actual %0d",
                           $time, want.opcode, rsp_opcode);
                  mismatch_count++;
               end
               if (rsp_out_last !== want.out_last) begin
                  $display("%0t: out_last expected %0d actual %0d",
                           $time, want.out_last, rsp_out_last);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) parse_frame_byte(req_in_byte, req_in_last);
      end
      pending_results = expected_results.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the frame unmasker testbench: clock, reset, frame stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_ITEMS = 950;
   localparam int HOLD_CYCLES  = 80;   // long receiver hold-off, fills the output stage
   localparam int DRAIN_CYCLES = 8;    // slack after every result is back

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_frame_kind;
   logic [3:0] rsp_opcode;
   logic       rsp_out_last;

   int mismatch_count;
   int pending_results;

   // calm turns off random idling on both sides; hold_go asks the receiver for a hold-off
   bit calm;
   bit hold_go;

   // bytes of the frame being built, {last, byte}
   logic [8:0] frame_beats [$];
   int         counted_items;

   websocket_text_frame_unmasker_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_opcode     (rsp_opcode),
      .rsp_out_last   (rsp_out_last)
   );

   wsu_unmask_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_in_last     (req_in_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_opcode      (rsp_opcode),
      .rsp_out_last    (rsp_out_last),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Safety net: ends the run with a fail if it never reaches its verdict.
   initial begin
      #2000000;
      $display("websocket_text_frame_unmasker_top regression: fail");
      $finish;
   end

   // Receiver: random stalls, none while calm, and a counted hold-off on request.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 12);
         end
      end
   end

   task automatic add_beat(input logic [7:0] b, input logic last);
      frame_beats.push_back({last, b});
   endtask

   // Set the last flag on the final byte of the frame being built.
   task automatic mark_last();
      logic [8:0] tail;
      tail = frame_beats.pop_back();
      frame_beats.push_back({1'b1, tail[7:0]});
   endtask

   // Text frame: first byte, length byte, extended length, key, payload.
   // cut >= 0 ends the frame inside the header (before the last key byte);
   // payload_len 0 without a cut ends it on the last key byte (empty text).
   task automatic build_text_frame(input logic [7:0] len_byte, input int payload_len,
                                   input int cut);
      int ext_bytes;
      int hdr_len;
      ext_bytes = (len_byte[6:0] == wsu_pkg::LEN_CODE_EXT16) ? int'(wsu_pkg::EXT16_BYTES) :
                  (len_byte[6:0] == wsu_pkg::LEN_CODE_EXT64) ? int'(wsu_pkg::EXT64_BYTES) : 0;
      hdr_len   = 2 + ext_bytes + int'(wsu_pkg::KEY_BYTES);
      add_beat(wsu_pkg::TEXT_FIN_BYTE, 1'b0);
      add_beat(len_byte, 1'b0);
      repeat (ext_bytes + int'(wsu_pkg::KEY_BYTES)) add_beat(8'($urandom_range(255)), 1'b0);
      if (cut >= 0) begin
         while (frame_beats.size() > cut % (hdr_len - 1) + 1) void'(frame_beats.pop_back());
      end else begin
         repeat (payload_len) add_beat(8'($urandom_range(255)), 1'b0);
      end
      mark_last();
      counted_items += frame_beats.size();
   endtask

   // Close or other frame: the first byte gives the result, the trailing bytes are dropped.
   task automatic build_control_frame(input logic [7:0] first_byte, input int trailing);
      add_beat(first_byte, 1'b0);
      repeat (trailing) add_beat(8'($urandom_range(255)), 1'b0);
      mark_last();
      counted_items += frame_beats.size();
   endtask

   // One item: optional idle cycles, then hold valid until the block takes it.
   task automatic send_item(input logic [8:0] beat);
      if (!calm) begin
         while ($urandom_range(99) < 12) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_in_byte <= beat[7:0];
      req_in_last <= beat[8];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_beats[i]) send_item(frame_beats[i]);
      frame_beats.delete();
   endtask

   // Pause the sender until every expected result is back.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   initial begin : stimulus
      int frame_no;
      int pick;
      int len_pick;
      logic [6:0] code;

      req_valid     <= 1'b0;
      req_in_byte   <= 8'h00;
      req_in_last   <= 1'b0;
      reset         <= 1'b1;
      calm          = 1'b0;
      hold_go       = 1'b0;
      counted_items = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed frames ---
      // text first byte that is also the last byte: truncated
      add_beat(wsu_pkg::TEXT_FIN_BYTE, 1'b1);
      send_frame();
      // bare close
      add_beat(wsu_pkg::CLOSE_FIN_BYTE, 1'b1);
      send_frame();
      // other opcode 0 with a trailing byte that is dropped
      add_beat(8'h00, 1'b0);
      add_beat(8'hFF, 1'b1);
      send_frame();
      // mask bit set, 16-bit extended length, extreme key and payload values
      add_beat(wsu_pkg::TEXT_FIN_BYTE, 1'b0);
      add_beat({1'b1, wsu_pkg::LEN_CODE_EXT16}, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'hFF, 1'b0);
      add_beat(8'hFF, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h5A, 1'b0);
      add_beat(8'hA5, 1'b0);
      add_beat(8'hFF, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h12, 1'b0);
      add_beat(8'h34, 1'b0);
      add_beat(8'h56, 1'b1);
      send_frame();
      // empty payload: last flag on the final key byte
      add_beat(wsu_pkg::TEXT_FIN_BYTE, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h11, 1'b0);
      add_beat(8'h22, 1'b0);
      add_beat(8'h33, 1'b0);
      add_beat(8'h44, 1'b1);
      send_frame();
      // 64-bit extended length cut off on its first byte
      add_beat(wsu_pkg::TEXT_FIN_BYTE, 1'b0);
      add_beat({1'b0, wsu_pkg::LEN_CODE_EXT64}, 1'b0);
      add_beat(8'h00, 1'b1);
      send_frame();
      wait_all_results();

      // --- receiver hold-off while the sender keeps pushing a long payload ---
      hold_go = 1'b1;
      build_text_frame({1'b1, 7'd40}, 40, -1);
      send_frame();
      wait_all_results();

      // --- random frames ---
      counted_items = 0;
      frame_no      = 0;
      while (counted_items < RANDOM_ITEMS) begin
         frame_no++;
         calm = (frame_no >= 60 && frame_no < 100);
         pick = int'($urandom_range(99));
         len_pick = int'($urandom_range(9));
         code = (len_pick < 6) ? 7'($urandom_range(125)) :
                (len_pick < 8) ? wsu_pkg::LEN_CODE_EXT16 : wsu_pkg::LEN_CODE_EXT64;
         if (pick < 65) begin
            build_text_frame({1'($urandom_range(1)), code},
                             ($urandom_range(99) < 10) ? int'($urandom_range(13, 48))
                                                       : int'($urandom_range(0, 12)), -1);
         end else if (pick < 75) begin
            build_text_frame({1'($urandom_range(1)), code}, 0, int'($urandom_range(15)));
         end else if (pick < 85) begin
            build_control_frame(wsu_pkg::CLOSE_FIN_BYTE, int'($urandom_range(0, 5)));
         end else begin
            build_control_frame(8'($urandom_range(255)), int'($urandom_range(0, 5)));
         end
         send_frame();
         if (frame_no == 150) wait_all_results();
      end
      calm = 1'b0;

      // --- drain and verdict ---
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("websocket_text_frame_unmasker_top regression: pass");
      end else begin
         $display("websocket_text_frame_unmasker_top regression: fail");
      end
      $finish;
   end

endmodule
